/* src/trd_pkg.sv */
// Shared types and constants for the timestamped record deframer.
package trd_pkg;

   // Reset value of the maximum payload length register
   localparam logic [31:0] MAX_FRAME_RESET = 32'd262144;

   // Header is eight bytes: four of timestamp, four of length
   localparam int HDR_CNT_W = 3;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_BAD_LEN = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      END_CLEAN     = 2'd0,
      END_BAD_LEN   = 2'd1,
      END_TRUNC_HDR = 2'd2,
      END_TRUNC_PAY = 2'd3
   } end_status_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_HALTED  = 3'b100
   } phase_type;

   // Input word action codes
   localparam logic ACT_DATA = 1'b0;
   localparam logic ACT_EOF  = 1'b1;

   // One result word as it leaves the parser
   typedef struct packed {
      logic           valid;
      kind_type       kind;
      logic [7:0]     payload_byte;
      logic           frame_last;
      logic [31:0]    frame_number;
      logic [31:0]    timestamp_ms;
      logic [31:0]    frame_length;
      end_status_type end_status;
      logic [31:0]    frames_total;
      logic [31:0]    duration_ms;
   } result_type;

endpackage

/* src/timestamped_record_deframer_core.sv */
// Top level of the timestamped record deframer: word registers and config.
//
// Usage: the req_ channel carries one word per file byte (req_action low,
// req_data_byte valid) or an end-of-file mark (req_action high). Each record
// is an 8-byte little-endian header (timestamp, then length) and its payload.
// The rsp_ channel returns a payload byte with its frame tags, a bad-length
// error, or an end-of-file summary; header bytes and data after a bad length
// return nothing. The csr_ channel writes the maximum payload length; it is
// always ready, and it is to be written by the user only while the block is
// idle, which the block itself does not enforce. Each result is built
// combinationally from the word in the input register and loads into the
// result register when that word advances. Throughput: one word per cycle
// while rsp_stall does not hold the result word, set by the parser between the two registers.
// Reset: synchronous; the stream state clears, the maximum length returns to
// 262144 and both registers empty. While rsp_stall is high the result word
// holds; once the input register also holds a word, req_stall follows
// rsp_stall in the same cycle.
module timestamped_record_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_last,
   output logic [31:0] rsp_frame_number,
   output logic [31:0] rsp_timestamp_ms,
   output logic [31:0] rsp_frame_length,
   output logic [1:0]  rsp_end_status,
   output logic [31:0] rsp_frames_total,
   output logic [31:0] rsp_duration_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import trd_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic        in_action_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] max_len_ff;
   logic        out_vld_ff, out_vld_in;
   result_type  out_word_ff;
   result_type  parse_res;
   logic        out_free;
   logic        fire;
   logic        req_take;

   // Advance a word when the result register can take whatever it gives
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Hold the maximum length register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_FRAME_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_data;
      end
   end

   // Input word register
   assign in_vld_in = req_take || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_data_byte;
      end
   end

   trd_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .action          (in_action_ff),
      .data_byte       (in_byte_ff),
      .max_frame_bytes (max_len_ff),
      .result          (parse_res)
   );

   // Result word register
   assign out_vld_in = fire ? parse_res.valid : (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && parse_res.valid) begin
         out_word_ff <= parse_res;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_kind         = out_word_ff.kind;
   assign rsp_payload_byte = out_word_ff.payload_byte;
   assign rsp_frame_last   = out_word_ff.frame_last;
   assign rsp_frame_number = out_word_ff.frame_number;
   assign rsp_timestamp_ms = out_word_ff.timestamp_ms;
   assign rsp_frame_length = out_word_ff.frame_length;
   assign rsp_end_status   = out_word_ff.end_status;
   assign rsp_frames_total = out_word_ff.frames_total;
   assign rsp_duration_ms  = out_word_ff.duration_ms;

`ifndef SYNTH
   // An end-of-file word always lands as a summary word
   a_eof_summary: assert property (@(posedge clock) disable iff (reset)
      (fire && in_action_ff == ACT_EOF) |=>
         (out_vld_ff && out_word_ff.kind == KIND_SUMMARY))
      else $error("end of file did not produce a summary word");

   // A blocked input word holds until it can advance
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !fire) |=>
         (in_vld_ff && $stable(in_byte_ff) && $stable(in_action_ff)))
      else $error("input word lost while blocked");

   // Last-byte mark only rides on payload words
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_word_ff.frame_last) |->
         (out_word_ff.kind == KIND_PAYLOAD))
      else $error("frame_last set on a non-payload word");

   // The input side stalls only while a word is held
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_vld_ff && out_vld_ff))
      else $error("stall raised with nothing held");
`endif

endmodule

/* src/trd_parser.sv */
// Record parser: header assembly, payload counting and result word build.
module trd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                action,
   input  logic [7:0]          data_byte,
   input  logic [31:0]         max_frame_bytes,
   output trd_pkg::result_type result
);
   import trd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [HDR_CNT_W-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]            cur_ts_ff, cur_ts_in;
   logic [31:0]            cur_len_ff, cur_len_in;
   logic [31:0]            remain_ff, remain_in;
   logic [31:0]            frames_ff, frames_in;
   logic [31:0]            last_ts_ff, last_ts_in;
   logic [31:0]            len_full;
   logic                   len_bad;
   logic                   pay_last;

   // Length as it stands once the final header byte shifts in
   assign len_full = {data_byte, cur_len_ff[31:8]};
   assign len_bad  = (len_full == 32'd0) || (len_full > max_frame_bytes);
   assign pay_last = (remain_ff == 32'd1);

   // Next state and result word for one processed input word
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      cur_ts_in  = cur_ts_ff;
      cur_len_in = cur_len_ff;
      remain_in  = remain_ff;
      frames_in  = frames_ff;
      last_ts_in = last_ts_ff;
      result     = '0;
      result.kind       = KIND_PAYLOAD;
      result.end_status = END_CLEAN;
      if (fire) begin
         if (action == ACT_EOF) begin
            // report the file summary, then clear for the next file
            result.valid        = 1'b1;
            result.kind         = KIND_SUMMARY;
            result.frames_total = frames_ff;
            result.duration_ms  = last_ts_ff;
            if (phase_ff == PH_HALTED) begin
               result.end_status = END_BAD_LEN;
            end else if (phase_ff == PH_PAYLOAD) begin
               result.end_status = END_TRUNC_PAY;
            end else if (hdr_cnt_ff != '0) begin
               result.end_status = END_TRUNC_HDR;
            end else begin
               result.end_status = END_CLEAN;
            end
            phase_in   = PH_HEADER;
            hdr_cnt_in = '0;
            cur_ts_in  = '0;
            cur_len_in = '0;
            remain_in  = '0;
            frames_in  = '0;
            last_ts_in = '0;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  // shift header bytes in, least significant first
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
                  if (hdr_cnt_ff[HDR_CNT_W-1] == 1'b0) begin
                     cur_ts_in = {data_byte, cur_ts_ff[31:8]};
                  end else begin
                     cur_len_in = len_full;
                  end
                  if (hdr_cnt_ff == {HDR_CNT_W{1'b1}}) begin
                     if (len_bad) begin
                        phase_in            = PH_HALTED;
                        result.valid        = 1'b1;
                        result.kind         = KIND_BAD_LEN;
                        result.frame_number = frames_ff;
                        result.timestamp_ms = cur_ts_ff;
                        result.frame_length = len_full;
                     end else begin
                        phase_in  = PH_PAYLOAD;
                        remain_in = len_full;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  // pass the byte through and count down the frame
                  remain_in           = remain_ff - 32'd1;
                  result.valid        = 1'b1;
                  result.kind         = KIND_PAYLOAD;
                  result.payload_byte = data_byte;
                  result.frame_last   = pay_last;
                  result.frame_number = frames_ff;
                  result.timestamp_ms = cur_ts_ff;
                  result.frame_length = cur_len_ff;
                  if (pay_last) begin
                     frames_in  = frames_ff + 32'd1;
                     last_ts_in = cur_ts_ff;
                     phase_in   = PH_HEADER;
                     hdr_cnt_in = '0;
                  end
               end
               PH_HALTED: begin
                  // drop data until end of file
                  phase_in = PH_HALTED;
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

   // Hold the stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         cur_ts_ff  <= '0;
         cur_len_ff <= '0;
         remain_ff  <= '0;
         frames_ff  <= '0;
         last_ts_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         cur_ts_ff  <= cur_ts_in;
         cur_len_ff <= cur_len_in;
         remain_ff  <= remain_in;
         frames_ff  <= frames_in;
         last_ts_ff <= last_ts_in;
      end
   end

endmodule
